// ----- sv/pbp_pkg.sv -----
`timescale 1ns / 1ps

package pbp_pkg;

  // Table geometry
  localparam int INDEX_BITS  = 10;
  localparam int HIST_LEN    = 32;
  localparam int WEIGHT_BITS = 8;
  localparam int ROWS        = 1 << INDEX_BITS;
  localparam int ROW_LEN     = HIST_LEN + 1;

  // Fixed field widths
  localparam int ADDR_W      = 32;
  localparam int SUM_W       = 14;
  localparam int THR_W       = 13;
  localparam int THR_RESET   = 75;
  localparam int IN_DATA_W   = ((ADDR_W + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((1 + SUM_W + 1 + 7) / 8) * 8;

  // Adder tree: groups of GROUP terms summed in the first stage
  localparam int GROUP       = 8;
  localparam int NGROUPS     = (ROW_LEN + GROUP - 1) / GROUP;
  localparam int PART_W      = WEIGHT_BITS + 1 + $clog2(GROUP);
  localparam int ACC_W_RAW   = PART_W + $clog2(NGROUPS) + 1;
  localparam int ACC_W       = (ACC_W_RAW > SUM_W + 1) ? ACC_W_RAW : SUM_W + 1;

  // Operation codes carried in tuser
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef logic [ROW_LEN-1:0][WEIGHT_BITS-1:0] row_t;
  typedef logic [HIST_LEN-1:0] hist_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Result item, predict_taken in the lowest bit
  typedef struct packed {
    logic trained;
    sum_t sum;
    logic predict_taken;
  } res_t;

endpackage

// ----- sv/pbp_weight_ram.sv -----
`timescale 1ns / 1ps

module pbp_weight_ram (
  input  logic              clk_i,
  input  logic              we_i,
  input  pbp_pkg::index_t   waddr_i,
  input  pbp_pkg::row_t     wdata_i,
  input  logic              re_i,
  input  pbp_pkg::index_t   raddr_i,
  output pbp_pkg::row_t     rdata_o
);

  pbp_pkg::row_t mem [pbp_pkg::ROWS];
  pbp_pkg::row_t rdata_q;

  // Write one full row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pbp_dot.sv -----
`timescale 1ns / 1ps

module pbp_dot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  pbp_pkg::row_t row_i,
  input  pbp_pkg::hist_t hist_i,
  output logic          valid_o,
  output pbp_pkg::sum_t sum_o
);

  localparam logic signed [pbp_pkg::ACC_W-1:0] SatHi =
    pbp_pkg::ACC_W'((2 ** (pbp_pkg::SUM_W - 1)) - 1);
  localparam logic signed [pbp_pkg::ACC_W-1:0] SatLo =
    pbp_pkg::ACC_W'(-(2 ** (pbp_pkg::SUM_W - 1)));

  logic [pbp_pkg::ROW_LEN-1:0] add_sel;
  logic signed [pbp_pkg::PART_W-1:0] part_d [pbp_pkg::NGROUPS];
  logic signed [pbp_pkg::PART_W-1:0] part_q [pbp_pkg::NGROUPS];
  logic signed [pbp_pkg::ACC_W-1:0] acc;
  pbp_pkg::sum_t sum_d, sum_q;
  logic v1_q, v2_q;

  // Align history with row entries; the bias is always added
  always_comb begin
    add_sel[0] = 1'b1;
    for (int j = 1; j < pbp_pkg::ROW_LEN; j++) begin
      add_sel[j] = hist_i[pbp_pkg::HIST_LEN-j];
    end
  end

  // Stage one: signed partial sums per group
  always_comb begin
    logic signed [pbp_pkg::WEIGHT_BITS-1:0] w;
    logic signed [pbp_pkg::PART_W-1:0] term;
    for (int g = 0; g < pbp_pkg::NGROUPS; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < pbp_pkg::GROUP; k++) begin
        if (g * pbp_pkg::GROUP + k < pbp_pkg::ROW_LEN) begin
          w = row_i[g * pbp_pkg::GROUP + k];
          term = pbp_pkg::PART_W'(w);
          if (!add_sel[g * pbp_pkg::GROUP + k]) begin
            term = -term;
          end
          part_d[g] = part_d[g] + term;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < pbp_pkg::NGROUPS; g++) begin
      part_q[g] <= part_d[g];
    end
  end

  // Stage two: total and saturate to the result width
  always_comb begin
    acc = '0;
    for (int g = 0; g < pbp_pkg::NGROUPS; g++) begin
      acc = acc + pbp_pkg::ACC_W'(part_q[g]);
    end
    if (acc > SatHi) begin
      sum_d = pbp_pkg::SUM_W'(SatHi);
    end else if (acc < SatLo) begin
      sum_d = pbp_pkg::SUM_W'(SatLo);
    end else begin
      sum_d = pbp_pkg::SUM_W'(acc);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Track valid through both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign sum_o   = sum_q;

endmodule

// ----- sv/pbp_train.sv -----
`timescale 1ns / 1ps

module pbp_train (
  input  pbp_pkg::row_t  row_i,
  input  pbp_pkg::hist_t hist_i,
  input  logic           taken_i,
  output pbp_pkg::row_t  row_o
);

  localparam logic signed [pbp_pkg::WEIGHT_BITS-1:0] WMax =
    pbp_pkg::WEIGHT_BITS'((2 ** (pbp_pkg::WEIGHT_BITS - 1)) - 1);
  localparam logic signed [pbp_pkg::WEIGHT_BITS-1:0] WMin =
    pbp_pkg::WEIGHT_BITS'(-(2 ** (pbp_pkg::WEIGHT_BITS - 1)));

  logic [pbp_pkg::ROW_LEN-1:0] up;

  // Bias follows the outcome; others move up on agreement
  always_comb begin
    up[0] = taken_i;
    for (int j = 1; j < pbp_pkg::ROW_LEN; j++) begin
      up[j] = (hist_i[pbp_pkg::HIST_LEN-j] == taken_i);
    end
  end

  // Saturating step on every weight
  always_comb begin
    logic signed [pbp_pkg::WEIGHT_BITS-1:0] w;
    for (int j = 0; j < pbp_pkg::ROW_LEN; j++) begin
      w = row_i[j];
      if (up[j]) begin
        row_o[j] = (w == WMax) ? w : w + pbp_pkg::WEIGHT_BITS'(1);
      end else begin
        row_o[j] = (w == WMin) ? w : w - pbp_pkg::WEIGHT_BITS'(1);
      end
    end
  end

endmodule

// ----- sv/perceptron_branch_predictor.sv -----
`timescale 1ns / 1ps

// Perceptron branch predictor.
// Input stream: tuser carries the operation (lookup or update), tdata carries
// the branch address and, for an update, the resolved outcome. Each input
// item yields exactly one result item on the output stream: the prediction
// and perceptron sum for a lookup, or the trained flag for an update.
// A lookup reads one weight row from the table, sums it through a two-stage
// adder tree (partial sums, then total) and registers the result at the output;
// an update reads the row, trains it and writes it back when training is needed.
// One item is in work at a time: a new item is accepted only after the result
// of the last one has been registered at the output or held in the block.
// After reset the table is cleared one row per cycle: input tready stays low
// until the last row is cleared. The threshold register may be written during that time.
// A stalled output holds its result; the next item is still accepted and its
// result waits in the block until the output register frees up.

module perceptron_branch_predictor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pbp_pkg::THR_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] branch_addr, [32] taken, [39:33] zero
  input  logic [pbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] predict_taken, [14:1] perceptron_sum, [15] trained
  output logic [pbp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  pbp_pkg::index_t clr_q;
  pbp_pkg::index_t idx_q;
  logic func_q, taken_q;
  pbp_pkg::hist_t hist_q;
  logic kept_pred_q;
  pbp_pkg::sum_t kept_sum_q;
  logic [pbp_pkg::THR_W-1:0] thr_q;
  pbp_pkg::res_t res_d, pend_q, out_q;
  logic out_valid_q;
  logic in_acc, out_free, fin;

  logic mem_we, mem_re;
  pbp_pkg::index_t mem_waddr;
  pbp_pkg::row_t mem_wdata, rdata, row_new;
  logic dot_valid;
  pbp_pkg::sum_t dot_sum;
  logic [pbp_pkg::SUM_W-1:0] mag;
  logic train;
  logic [pbp_pkg::HIST_LEN:0] hist_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Training decision from the kept lookup
  assign mag   = kept_sum_q[pbp_pkg::SUM_W-1] ? -kept_sum_q : kept_sum_q;
  assign train = (kept_pred_q != taken_q) || (mag <= {1'b0, thr_q});

  // Memory port control: clearing pass, then updates
  assign mem_re    = in_acc;
  assign mem_we    = (state_q == ST_CLEAR) ||
                     ((state_q == ST_EXEC) && (func_q == pbp_pkg::FUNC_UPDATE) && train);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : row_new;

  pbp_weight_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (s_axis_tdata[pbp_pkg::INDEX_BITS-1:0]),
    .rdata_o (rdata)
  );

  pbp_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i ((state_q == ST_EXEC) && (func_q == pbp_pkg::FUNC_LOOKUP)),
    .row_i   (rdata),
    .hist_i  (hist_q),
    .valid_o (dot_valid),
    .sum_o   (dot_sum)
  );

  pbp_train u_train (
    .row_i   (rdata),
    .hist_i  (hist_q),
    .taken_i (taken_q),
    .row_o   (row_new)
  );

  // Result and sequencing
  always_comb begin
    fin     = 1'b0;
    res_d   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (func_q == pbp_pkg::FUNC_UPDATE) begin
          fin           = 1'b1;
          res_d.trained = train;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (dot_valid) begin
          fin                 = 1'b1;
          res_d.sum           = dot_sum;
          res_d.predict_taken = !dot_sum[pbp_pkg::SUM_W-1] && (dot_sum != '0);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  assign hist_ext = {taken_q, hist_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hist_q      <= '0;
      kept_pred_q <= 1'b0;
      kept_sum_q  <= '0;
      thr_q       <= pbp_pkg::THR_W'(pbp_pkg::THR_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // Shift the outcome into the top of the history
      if ((state_q == ST_EXEC) && (func_q == pbp_pkg::FUNC_UPDATE)) begin
        hist_q <= hist_ext[pbp_pkg::HIST_LEN:1];
      end
      // Keep the lookup result for the next update
      if ((state_q == ST_WAIT) && dot_valid) begin
        kept_pred_q <= res_d.predict_taken;
        kept_sum_q  <= res_d.sum;
      end
      if ((fin && out_free) || ((state_q == ST_DONE) && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q   <= s_axis_tdata[pbp_pkg::INDEX_BITS-1:0];
      taken_q <= s_axis_tdata[pbp_pkg::ADDR_W];
      func_q  <= s_axis_tuser;
    end
    if (fin) begin
      pend_q <= res_d;
    end
    if (fin && out_free) begin
      out_q <= res_d;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pbp_pkg::OUT_DATA_W'(out_q);

endmodule
